// File: rtl/core/srfc_pkg.sv
// Package for the sensor reply frame checker: constants, status codes and the result type.
`default_nettype none

package srfc_pkg;

	// Frame layout
	localparam int unsigned FRAME_LEN = 9;
	localparam int unsigned COUNT_W   = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	// Byte positions inside a frame
	localparam logic [COUNT_W-1:0] POS_HDR0  = COUNT_W'(0);
	localparam logic [COUNT_W-1:0] POS_HDR1  = COUNT_W'(1);
	localparam logic [COUNT_W-1:0] POS_VALHI = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] POS_VALLO = COUNT_W'(3);
	localparam logic [COUNT_W-1:0] POS_SUMLAST = COUNT_W'(FRAME_LEN - 2);
	localparam logic [COUNT_W-1:0] POS_CHECK = COUNT_W'(FRAME_LEN - 1);

	// Configuration register indexes and reset values
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 8'd1;
	localparam logic [7:0] HEADER_FIRST_RST  = 8'hFF;
	localparam logic [7:0] HEADER_SECOND_RST = 8'h86;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LENGTH   = 2'd1,
		ST_HEADER   = 2'd2,
		ST_CHECKSUM = 2'd3
	} srfc_status_t;

	typedef struct packed {
		srfc_status_t status;
		logic [15:0]  concentration;
	} srfc_result_t;

endpackage

`default_nettype wire

// File: rtl/core/srfc_frame.sv
// Frame state tracker and judge: updates per byte, gives the verdict on the burst's last byte.
`default_nettype none

module srfc_frame
	import srfc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         burst_end,
	input  wire logic [7:0]   header_first,
	input  wire logic [7:0]   header_second,
	output srfc_result_t      result
);

	logic [COUNT_W-1:0] byte_count_q;
	logic               header_match_q;
	logic [7:0]         running_sum_q;
	logic [7:0]         value_high_q;
	logic [7:0]         value_low_q;
	logic [7:0]         check_byte_q;

	logic               header_match_d;
	logic [7:0]         running_sum_d;
	logic [7:0]         value_high_d;
	logic [7:0]         value_low_d;
	logic [7:0]         check_byte_d;
	logic [COUNT_W-1:0] byte_count_d;

	// Take the current byte into the frame state
	always_comb begin
		header_match_d = header_match_q;
		running_sum_d  = running_sum_q;
		value_high_d   = value_high_q;
		value_low_d    = value_low_q;
		check_byte_d   = check_byte_q;
		if (byte_count_q == POS_HDR0 && rx_byte != header_first) begin
			header_match_d = 1'b0;
		end
		if (byte_count_q == POS_HDR1 && rx_byte != header_second) begin
			header_match_d = 1'b0;
		end
		if (byte_count_q >= POS_HDR1 && byte_count_q <= POS_SUMLAST) begin
			running_sum_d = running_sum_q + rx_byte;
		end
		if (byte_count_q == POS_VALHI) begin
			value_high_d = rx_byte;
		end
		if (byte_count_q == POS_VALLO) begin
			value_low_d = rx_byte;
		end
		if (byte_count_q == POS_CHECK) begin
			check_byte_d = rx_byte;
		end
		byte_count_d = (byte_count_q == COUNT_MAX) ? byte_count_q : byte_count_q + 1'b1;
	end

	// Verdict: length first, then header, then checksum
	always_comb begin
		result.status        = ST_OK;
		result.concentration = '0;
		if (byte_count_q != POS_CHECK) begin
			result.status = ST_LENGTH;
		end else if (!header_match_d) begin
			result.status = ST_HEADER;
		end else if (check_byte_d != 8'(8'd0 - running_sum_d)) begin
			result.status = ST_CHECKSUM;
		end else begin
			result.concentration = {value_high_d, value_low_d};
		end
	end

	// Frame state registers, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			header_match_q <= 1'b1;
			running_sum_q  <= '0;
			value_high_q   <= '0;
			value_low_q    <= '0;
			check_byte_q   <= '0;
		end else if (step) begin
			if (burst_end) begin
				byte_count_q   <= '0;
				header_match_q <= 1'b1;
				running_sum_q  <= '0;
				value_high_q   <= '0;
				value_low_q    <= '0;
				check_byte_q   <= '0;
			end else begin
				byte_count_q   <= byte_count_d;
				header_match_q <= header_match_d;
				running_sum_q  <= running_sum_d;
				value_high_q   <= value_high_d;
				value_low_q    <= value_low_d;
				check_byte_q   <= check_byte_d;
			end
		end
	end

`ifndef ASSERT_OFF
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && burst_end |=> byte_count_q == '0 && header_match_q && running_sum_q == '0)
		else $error("frame state not cleared after burst end");
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(byte_count_q) && $stable(running_sum_q))
		else $error("frame state changed without a byte");
	a_ok_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		step && burst_end && result.status == ST_OK |-> byte_count_q == POS_CHECK)
		else $error("ok verdict on a frame of wrong length");
	a_zero_conc_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		result.status != ST_OK |-> result.concentration == '0)
		else $error("nonzero concentration on a failed frame");
`endif

endmodule

`default_nettype wire

// File: rtl/core/sensor_response_frame_checker_top.sv
// Path: a byte is registered, then judged; the verdict on a burst's last byte is held in the result register.
// Throughput: one byte per cycle when not stalled; per-byte update and verdict fit between two registers.
// A held result stalls input only when the next byte to be judged is a burst's last byte.
// Reset: arst_n clears frame state, empties both stages and loads the header defaults.
// Configuration writes are always taken (cfg_ready is high) and go straight into the header registers.
`default_nettype none

module sensor_response_frame_checker_top
	import srfc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// byte input
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 burst_end,
	// result output
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                status,
	output logic [15:0]               concentration,
	// configuration
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_valid_q;
	srfc_result_t result_q;
	srfc_result_t verdict;
	logic [7:0]   header_first_q;
	logic [7:0]   header_second_q;
	logic         out_free;
	logic         step;
	logic         accept;

	// Handshake: a last byte moves only when the result register can take its result
	assign out_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && (!last_s1 || out_free);
	assign in_stall  = valid_s1 && !step;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_first_q  <= HEADER_FIRST_RST;
			header_second_q <= HEADER_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_HEADER_FIRST) begin
				header_first_q <= cfg_data;
			end else if (cfg_index == CFG_HEADER_SECOND) begin
				header_second_q <= cfg_data;
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
			last_s1 <= burst_end;
		end
	end

	srfc_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.rx_byte       (byte_s1),
		.burst_end     (last_s1),
		.header_first  (header_first_q),
		.header_second (header_second_q),
		.result        (verdict)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			result_q <= verdict;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = result_q.status;
	assign concentration = result_q.concentration;

`ifndef ASSERT_OFF
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked last byte");
	a_result_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> out_valid_q)
		else $error("last byte judged but no result raised");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall && !(step && last_s1) |=> out_valid_q && $stable(result_q))
		else $error("held result lost or changed");
`endif

endmodule

`default_nettype wire
